### rtl/core/gmd_pkg.sv
// Shared types and constants for the gzip member deframer.
// Holds the result record, the status codes and the result queue sizing.
// No dependencies.
package gmd_pkg;

  localparam int unsigned ByteW        = 8;
  localparam int unsigned WordW        = 32;
  localparam logic [WordW-1:0] MaxSizeReset = 32'd268435456;
  localparam int unsigned ResFifoDepth = 4;
  localparam int unsigned MaxResPerItem = 2;

  typedef enum logic [3:0] {
    StOk         = 4'd0,
    StShort      = 4'd1,
    StMagic      = 4'd2,
    StMethod     = 4'd3,
    StXlenCut    = 4'd4,
    StExtraCut   = 4'd5,
    StName       = 4'd6,
    StComment    = 4'd7,
    StHcrc       = 4'd8,
    StTruncated  = 4'd9,
    StEmpty      = 4'd10,
    StTooLarge   = 4'd11
  } status_e;

  typedef struct packed {
    logic              kind;
    logic [ByteW-1:0]  payload_byte;
    logic              run_last;
    status_e           status;
    logic [WordW-1:0]  expected_crc;
    logic [WordW-1:0]  expected_size;
  } result_t;

  // Results produced by one item, packed to the front: res0 first, then res1.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } result_pair_t;

endpackage

### rtl/core/gmd_parser.sv
// Header walker and trailer delay line for the gzip member deframer.
// Updates the per-member state on each accepted byte and forms up to two results.
// Depends on gmd_pkg.
module gmd_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [7:0]                in_byte_i,
  input  logic                      in_last_i,
  input  logic [31:0]               max_output_size_i,
  output gmd_pkg::result_pair_t     results_o
);
  import gmd_pkg::*;

  typedef enum logic [7:0] {
    PhFixed   = 8'b0000_0001,
    PhXlen    = 8'b0000_0010,
    PhExtra   = 8'b0000_0100,
    PhName    = 8'b0000_1000,
    PhComment = 8'b0001_0000,
    PhHcrc    = 8'b0010_0000,
    PhPayload = 8'b0100_0000,
    PhDiscard = 8'b1000_0000
  } phase_e;

  localparam logic [4:0] FlagHcrc    = 5'h02;
  localparam logic [4:0] FlagExtra   = 5'h04;
  localparam logic [4:0] FlagName    = 5'h08;
  localparam logic [4:0] FlagComment = 5'h10;
  localparam logic [4:0] TotalMin    = 5'd18;
  localparam logic [3:0] FixedLast   = 4'd9;
  localparam logic [3:0] FillFull    = 4'd8;
  localparam logic [3:0] FillPassed  = 4'd9;

  // Order of the optional sections, used to find the next one the flags ask for.
  localparam logic [2:0] RankFixed   = 3'd0;
  localparam logic [2:0] RankExtra   = 3'd2;
  localparam logic [2:0] RankName    = 3'd3;
  localparam logic [2:0] RankComment = 3'd4;
  localparam logic [2:0] RankHcrc    = 3'd5;

  function automatic phase_e section_after(logic [2:0] done, logic [4:0] flags);
    phase_e ph;
    if (done < RankExtra && (flags & FlagExtra) != '0) begin
      ph = PhXlen;
    end else if (done < RankName && (flags & FlagName) != '0) begin
      ph = PhName;
    end else if (done < RankComment && (flags & FlagComment) != '0) begin
      ph = PhComment;
    end else if (done < RankHcrc && (flags & FlagHcrc) != '0) begin
      ph = PhHcrc;
    end else begin
      ph = PhPayload;
    end
    return ph;
  endfunction

  phase_e      phase_q, phase_d;
  logic [3:0]  hdr_pos_q, hdr_pos_d;
  logic [4:0]  flags_q, flags_d;
  logic [7:0]  xlen_lo_q, xlen_lo_d;
  logic [15:0] field_rem_q, field_rem_d;
  logic [7:0]  delay_q [8];
  logic [7:0]  delay_d [8];
  logic [3:0]  fill_q, fill_d;
  status_e     first_err_q, first_err_d;
  logic [4:0]  total_q, total_d;

  logic        pay_valid;
  logic [7:0]  pay_byte;
  status_e     st;
  logic [31:0] crc_word;
  logic [31:0] size_word;
  result_t     pay_res;
  result_t     st_res;

  always_comb begin
    phase_d     = phase_q;
    hdr_pos_d   = hdr_pos_q;
    flags_d     = flags_q;
    xlen_lo_d   = xlen_lo_q;
    field_rem_d = field_rem_q;
    delay_d     = delay_q;
    fill_d      = fill_q;
    first_err_d = first_err_q;
    total_d     = (total_q < TotalMin) ? total_q + 5'd1 : total_q;
    pay_valid   = 1'b0;
    pay_byte    = delay_q[0];

    unique case (phase_q)
      PhFixed: begin
        if (hdr_pos_q == 4'd0 && in_byte_i != 8'h1F) begin
          first_err_d = StMagic;
          phase_d     = PhDiscard;
        end else if (hdr_pos_q == 4'd1 && in_byte_i != 8'h8B) begin
          first_err_d = StMagic;
          phase_d     = PhDiscard;
        end else if (hdr_pos_q == 4'd2 && in_byte_i != 8'h08) begin
          first_err_d = StMethod;
          phase_d     = PhDiscard;
        end else begin
          if (hdr_pos_q == 4'd3) begin
            flags_d = in_byte_i[4:0];
          end
          if (hdr_pos_q >= FixedLast) begin
            hdr_pos_d = 4'd0;
            phase_d   = section_after(RankFixed, flags_q);
          end else begin
            hdr_pos_d = hdr_pos_q + 4'd1;
          end
        end
      end
      PhXlen: begin
        if (hdr_pos_q == 4'd0) begin
          xlen_lo_d = in_byte_i;
          hdr_pos_d = 4'd1;
        end else begin
          field_rem_d = {in_byte_i, xlen_lo_q};
          hdr_pos_d   = 4'd0;
          phase_d     = ({in_byte_i, xlen_lo_q} != 16'd0) ? PhExtra
                                                          : section_after(RankExtra, flags_q);
        end
      end
      PhExtra: begin
        field_rem_d = (field_rem_q != 16'd0) ? field_rem_q - 16'd1 : field_rem_q;
        if (field_rem_d == 16'd0) begin
          phase_d = section_after(RankExtra, flags_q);
        end
      end
      PhName: begin
        if (in_byte_i == 8'd0) begin
          phase_d = section_after(RankName, flags_q);
        end
      end
      PhComment: begin
        if (in_byte_i == 8'd0) begin
          phase_d = section_after(RankComment, flags_q);
        end
      end
      PhHcrc: begin
        if (hdr_pos_q == 4'd0) begin
          hdr_pos_d = 4'd1;
        end else begin
          hdr_pos_d = 4'd0;
          phase_d   = section_after(RankHcrc, flags_q);
        end
      end
      PhPayload: begin
        // Once eight bytes are held, the oldest leaves as payload and the rest shift down.
        if (fill_q >= FillFull) begin
          pay_valid = 1'b1;
          for (int i = 0; i < 7; i++) begin
            delay_d[i] = delay_q[i+1];
          end
          delay_d[7] = in_byte_i;
          fill_d     = FillPassed;
        end else begin
          delay_d[fill_q[2:0]] = in_byte_i;
          fill_d               = fill_q + 4'd1;
        end
      end
      PhDiscard: begin
      end
      default: begin
      end
    endcase
  end

  assign crc_word  = {delay_d[3], delay_d[2], delay_d[1], delay_d[0]};
  assign size_word = {delay_d[7], delay_d[6], delay_d[5], delay_d[4]};

  always_comb begin
    if (total_d < TotalMin) begin
      st = StShort;
    end else if (first_err_d != StOk) begin
      st = first_err_d;
    end else if (phase_d == PhXlen) begin
      st = StXlenCut;
    end else if (phase_d == PhExtra) begin
      st = StExtraCut;
    end else if (phase_d == PhName) begin
      st = StName;
    end else if (phase_d == PhComment) begin
      st = StComment;
    end else if (phase_d == PhHcrc) begin
      st = StHcrc;
    end else if (phase_d != PhPayload || fill_d < FillFull) begin
      st = StTruncated;
    end else if (fill_d == FillFull) begin
      st = StEmpty;
    end else if (size_word > max_output_size_i) begin
      st = StTooLarge;
    end else begin
      st = StOk;
    end
  end

  always_comb begin
    pay_res              = '0;
    pay_res.kind         = 1'b0;
    pay_res.payload_byte = pay_byte;
    pay_res.status       = StOk;

    st_res               = '0;
    st_res.kind          = 1'b1;
    st_res.run_last      = 1'b1;
    st_res.status        = st;
    if (st == StOk || st == StTooLarge) begin
      st_res.expected_crc  = crc_word;
      st_res.expected_size = size_word;
    end

    results_o.res0  = pay_valid ? pay_res : st_res;
    results_o.res1  = st_res;
    results_o.count = '0;
    if (accept_i) begin
      results_o.count = {1'b0, pay_valid} + {1'b0, in_last_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhFixed;
      hdr_pos_q   <= '0;
      flags_q     <= '0;
      xlen_lo_q   <= '0;
      field_rem_q <= '0;
      fill_q      <= '0;
      first_err_q <= StOk;
      total_q     <= '0;
    end else if (accept_i) begin
      if (in_last_i) begin
        // The status result closes the member; start the next one from scratch.
        phase_q     <= PhFixed;
        hdr_pos_q   <= '0;
        flags_q     <= '0;
        xlen_lo_q   <= '0;
        field_rem_q <= '0;
        fill_q      <= '0;
        first_err_q <= StOk;
        total_q     <= '0;
      end else begin
        phase_q     <= phase_d;
        hdr_pos_q   <= hdr_pos_d;
        flags_q     <= flags_d;
        xlen_lo_q   <= xlen_lo_d;
        field_rem_q <= field_rem_d;
        fill_q      <= fill_d;
        first_err_q <= first_err_d;
        total_q     <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      delay_q <= delay_d;
    end
  end

endmodule

### rtl/core/gmd_res_fifo.sv
// Result queue for the gzip member deframer: takes up to two results a cycle,
// hands out one a cycle under valid and stall. Depends on gmd_pkg.
module gmd_res_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gmd_pkg::result_pair_t  push_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output gmd_pkg::result_t       head_o
);
  import gmd_pkg::*;

  localparam int unsigned PtrW = $clog2(ResFifoDepth);
  localparam int unsigned CntW = $clog2(ResFifoDepth + 1);
  localparam logic [CntW-1:0] RoomLimit = CntW'(ResFifoDepth - MaxResPerItem);

  result_t         mem_q [ResFifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;
  logic [PtrW-1:0] wr_ptr_next;

  assign pop         = (count_q != '0) && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  // Room is judged on the stored count alone, so stall never waits on valid.
  assign room_o      = (count_q <= RoomLimit);
  assign wr_ptr_next = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_next] <= push_i.res1;
    end
  end

endmodule

### rtl/core/gzip_member_deframer.sv
// Top level of the gzip member deframer: size limit register, header walker
// and result queue. Depends on gmd_pkg, gmd_parser and gmd_res_fifo.
//
// Takes one gzip member a byte per cycle while not stalled (in_last_i on its
// final byte), checks magic and method, skips the fixed header and the optional
// extra, name, comment and header CRC fields, and passes deflate payload bytes on
// through an eight-byte delay so the trailer is never emitted as payload. On the
// last byte a status item follows with the first failure found and, for an OK or
// too-large status, the trailer's CRC and size. Every byte is processed in the
// cycle it is accepted, so the input runs at one item per cycle while in_stall_o
// is low; the final byte may produce two results, and the four-entry result queue
// then absorbs the extra one. Input stall rises only when the queue holds more
// than two results, which happens when the output side stalls. Payload results
// are speculative: a nonzero status marks the member as bad after its bytes went
// out. Write max_output_size only while no member is in flight.
module gzip_member_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        run_last_o,
  output logic [3:0]  status_o,
  output logic [31:0] expected_crc_o,
  output logic [31:0] expected_size_o
);
  import gmd_pkg::*;

  logic [WordW-1:0] max_size_q;
  logic             accept;
  logic             room;
  result_pair_t     results;
  result_t          head;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= MaxSizeReset;
    end else if (cfg_we_i) begin
      max_size_q <= cfg_wdata_i;
    end
  end

  gmd_parser u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .in_byte_i         (in_byte_i),
    .in_last_i         (in_last_i),
    .max_output_size_i (max_size_q),
    .results_o         (results)
  );

  gmd_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (results),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o          = head.kind;
  assign payload_byte_o  = head.payload_byte;
  assign run_last_o      = head.run_last;
  assign status_o        = head.status;
  assign expected_crc_o  = head.expected_crc;
  assign expected_size_o = head.expected_size;

endmodule
